@@ src/frustum_ring_tessellator_assert.svh @@
// assertion macros shared by the tessellator rtl
`ifndef FRUSTUM_RING_TESSELLATOR_ASSERT_SVH
`define FRUSTUM_RING_TESSELLATOR_ASSERT_SVH

// condition implies consequence in the same cycle
`define FTR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ftr assertion failed");

// condition implies consequence in the next cycle
`define FTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ftr assertion failed");

`endif

@@ src/ftr_pkg.sv @@
// ----------------------------------------------------------------------------
// ftr_pkg
// shared constants, types and the sine table of the frustum ring tessellator
// ----------------------------------------------------------------------------
package ftr_pkg;

  localparam int MAX_DETAIL  = 4;
  localparam int COORD_W     = 32;
  localparam int DIR_W       = 16;
  localparam int LEN_W       = 31;
  localparam int MAG_W       = 32;
  localparam int SQ_W        = 64;
  localparam int UNIT_SH     = 14;
  localparam int DIV_W       = 48;
  localparam int DIV_STEPS   = 15;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [2:0] TEX_V_TOP = 3'd5;

  typedef struct packed {
    logic [2:0] neg;
    logic [2:0][MAG_W-1:0] mag;
  } norm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [2:0][DIR_W-1:0] res;
  } norm_stat_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] org;
    logic [2:0][DIR_W-1:0] head;
    logic [2:0][DIR_W-1:0] left;
    logic [2:0][DIR_W-1:0] up;
    logic [LEN_W-1:0] rad_bot;
    logic [LEN_W-1:0] rad_top;
    logic [LEN_W-1:0] len;
  } branch_t;

  function automatic logic [14:0] quarter_sine(input logic [3:0] i);
    logic [14:0] v;
    case (i)
      4'd0: v = 15'd0;
      4'd1: v = 15'd3196;
      4'd2: v = 15'd6270;
      4'd3: v = 15'd9102;
      4'd4: v = 15'd11585;
      4'd5: v = 15'd13623;
      4'd6: v = 15'd15137;
      4'd7: v = 15'd16069;
      4'd8: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // 32 steps per turn
  function automatic logic signed [DIR_W-1:0] sine_at(input logic [4:0] m);
    logic [3:0] idx;
    logic [DIR_W-1:0] v;
    idx = m[3] ? (4'd8 - {1'b0, m[2:0]}) : {1'b0, m[2:0]};
    v = {1'b0, quarter_sine(idx)};
    return m[4] ? -$signed(v) : $signed(v);
  endfunction

endpackage

@@ src/ftr_ifc.sv @@
// ----------------------------------------------------------------------------
// ftr_in_if / ftr_out_if
// valid/ready channels for branch descriptions and ring vertices
// ----------------------------------------------------------------------------
interface ftr_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [15:0] heading_x;
  logic signed [15:0] heading_y;
  logic signed [15:0] heading_z;
  logic signed [15:0] left_x;
  logic signed [15:0] left_y;
  logic signed [15:0] left_z;
  logic [30:0] bottom_radius;
  logic [30:0] top_radius;
  logic [30:0] branch_length;

  modport source (
    output valid, origin_x, origin_y, origin_z, heading_x, heading_y, heading_z,
    output left_x, left_y, left_z, bottom_radius, top_radius, branch_length,
    input ready
  );
  modport sink (
    input valid, origin_x, origin_y, origin_z, heading_x, heading_y, heading_z,
    input left_x, left_y, left_z, bottom_radius, top_radius, branch_length,
    output ready
  );
endinterface

interface ftr_out_if;
  logic valid;
  logic ready;
  logic [5:0] vertex_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [4:0] tex_u;
  logic [2:0] tex_v;
  logic last;

  modport source (
    output valid, vertex_index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
    output tex_u, tex_v, last,
    input ready
  );
  modport sink (
    input valid, vertex_index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
    input tex_u, tex_v, last,
    output ready
  );
endinterface

@@ src/frustum_ring_tessellator.sv @@
// the front prepares the ring data of an accepted branch, then the back emits
// its vertices one at a time, 2V vertices per branch (V = 4..32).
// the pace per branch is set by the square root and divide loop of the vertex
// normalizer; up to two more branches wait prepared in the queue.
// reset: synchronous, active high; detail_level returns to 2, queue empties.
// ----------------------------------------------------------------------------
// frustum_ring_tessellator
// branch in, bottom and top ring vertices out with normals and tex coords
// ----------------------------------------------------------------------------
module frustum_ring_tessellator
  import ftr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  ftr_in_if.sink     in_ch,
  ftr_out_if.source  out_ch
);

  `include "frustum_ring_tessellator_assert.svh"

  logic [2:0] detail_level;
  logic [2:0] detail;
  logic q_push, q_pop, q_full, q_empty;
  branch_t q_din, q_dout;

  always_ff @(posedge clk) begin
    if (rst) detail_level <= 3'd2;
    else if (cfg_we) detail_level <= cfg_wdata;
  end

  // level zero acts as one, anything above the top level as the top level
  always_comb begin
    if (detail_level == 3'd0) detail = 3'd1;
    else if (detail_level > 3'(MAX_DETAIL)) detail = 3'(MAX_DETAIL);
    else detail = detail_level;
  end

  ftr_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_din  (q_din)
  );

  ftr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  ftr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .detail  (detail),
    .q_empty (q_empty),
    .q_dout  (q_dout),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  `FTR_ASSERT_NOW(a_push_not_full, clk, rst, q_push, !q_full)
  `FTR_ASSERT_NOW(a_pop_not_empty, clk, rst, q_pop, !q_empty)
  `FTR_ASSERT_NOW(a_last_on_top, clk, rst, out_ch.valid && out_ch.last, out_ch.tex_v == TEX_V_TOP)
  `FTR_ASSERT_NEXT(a_pop_no_repeat, clk, rst, q_pop, !q_pop)

endmodule

@@ src/ftr_norm.sv @@
// ----------------------------------------------------------------------------
// ftr_norm
// iterative vector normalizer: sum of squares, bitwise square root, and a
// restoring divide per component, result in q1.14
// ----------------------------------------------------------------------------
module ftr_norm
  import ftr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  norm_req_t  req,
  output norm_stat_t stat
);

  typedef enum logic [4:0] {
    N_IDLE = 5'b00001,
    N_SQ   = 5'b00010,
    N_ROOT = 5'b00100,
    N_LOAD = 5'b01000,
    N_DIV  = 5'b10000
  } nstate_t;

  nstate_t state;
  norm_req_t req_r;
  logic [3:0] cnt;
  logic [1:0] ci;
  logic [SQ_W-1:0] sq, acc, x, r, bitm;
  logic [MAG_W-1:0] s;
  logic [DIV_W-1:0] rem, dv;
  logic [DIV_STEPS-1:0] q;
  logic done;
  logic [2:0][DIR_W-1:0] res;

  logic [1:0] sel;
  logic [MAG_W-1:0] mag_sel;
  logic [SQ_W-1:0] sq_n, acc_n, rb, x_n, r_n;
  logic root_ge, div_ge;
  logic [DIV_STEPS-1:0] q_n;
  logic [DIR_W-1:0] qext;

  always_comb begin
    sel = (cnt[1:0] == 2'd3) ? 2'd0 : cnt[1:0];
    mag_sel = req_r.mag[sel];
    sq_n = SQ_W'(mag_sel) * SQ_W'(mag_sel);
    acc_n = acc + sq;
    rb = r + bitm;
    root_ge = (x >= rb);
    x_n = root_ge ? (x - rb) : x;
    r_n = root_ge ? ((r >> 1) + bitm) : (r >> 1);
    div_ge = (rem >= dv);
    q_n = {q[DIV_STEPS-2:0], div_ge};
    qext = {1'b0, q_n};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            req_r <= req;
            cnt <= '0;
            acc <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          sq <= sq_n;
          if (cnt != 4'd0) acc <= acc_n;
          cnt <= cnt + 4'd1;
          if (cnt == 4'd3) begin
            if (acc_n == '0) begin
              res <= '0;
              done <= 1'b1;
              state <= N_IDLE;
            end else begin
              x <= acc_n;
              r <= '0;
              bitm <= SQ_W'(1) << (SQ_W - 2);
              state <= N_ROOT;
            end
          end
        end
        N_ROOT: begin
          x <= x_n;
          r <= r_n;
          bitm <= bitm >> 2;
          if (bitm[0]) begin
            s <= r_n[MAG_W-1:0];
            ci <= '0;
            state <= N_LOAD;
          end
        end
        N_LOAD: begin
          rem <= DIV_W'({req_r.mag[ci], UNIT_SH'(0)}) + DIV_W'(s >> 1);
          dv <= DIV_W'({s, UNIT_SH'(0)});
          q <= '0;
          cnt <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          if (div_ge) rem <= rem - dv;
          dv <= dv >> 1;
          q <= q_n;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(DIV_STEPS - 1)) begin
            res[ci] <= req_r.neg[ci] ? DIR_W'(-qext) : qext;
            if (ci == 2'd2) begin
              done <= 1'b1;
              state <= N_IDLE;
            end else begin
              ci <= ci + 2'd1;
              state <= N_LOAD;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != N_IDLE);
  assign stat.done = done;
  assign stat.res  = res;

endmodule

@@ src/ftr_front.sv @@
// ----------------------------------------------------------------------------
// ftr_front
// takes a branch, normalizes heading and left, builds the up vector
// ----------------------------------------------------------------------------
module ftr_front
  import ftr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  ftr_in_if.sink  in_ch,
  input  logic    q_full,
  output logic    q_push,
  output branch_t q_din
);

  typedef enum logic [6:0] {
    F_IDLE  = 7'b0000001,
    F_HEAD  = 7'b0000010,
    F_LEFT  = 7'b0000100,
    F_CROSS = 7'b0001000,
    F_UPGO  = 7'b0010000,
    F_UP    = 7'b0100000,
    F_PUSH  = 7'b1000000
  } fstate_t;

  fstate_t state;
  logic [2:0][COORD_W-1:0] org;
  logic [2:0][DIR_W-1:0] lraw, head, left, up;
  logic [LEN_W-1:0] rad_bot, rad_top, len;
  logic [2:0][COORD_W-1:0] cr;
  logic [1:0] cc;
  logic nstart;
  norm_req_t nreq;
  norm_stat_t nstat;

  norm_req_t lreq, ureq;
  logic [1:0] i1, i2;
  logic signed [COORD_W:0] cr_n;
  logic [DIR_W-1:0] a16;
  logic [MAG_W-1:0] a32;

  ftr_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nstart),
    .req   (nreq),
    .stat  (nstat)
  );

  always_comb begin
    lreq = '0;
    ureq = '0;
    for (int i = 0; i < 3; i++) begin
      lreq.neg[i] = lraw[i][DIR_W-1];
      a16 = lraw[i][DIR_W-1] ? DIR_W'(-$signed(lraw[i])) : lraw[i];
      lreq.mag[i] = MAG_W'({a16, UNIT_SH'(0)});
      ureq.neg[i] = cr[i][COORD_W-1];
      a32 = cr[i][COORD_W-1] ? MAG_W'(-$signed(cr[i])) : cr[i];
      ureq.mag[i] = a32;
    end
    case (cc)
      2'd0: begin i1 = 2'd1; i2 = 2'd2; end
      2'd1: begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
    cr_n = (COORD_W+1)'($signed(head[i1]) * $signed(left[i2]))
         - (COORD_W+1)'($signed(head[i2]) * $signed(left[i1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      nstart <= 1'b0;
    end else begin
      nstart <= 1'b0;
      case (state)
        F_IDLE: begin
          if (in_ch.valid) begin
            org <= {in_ch.origin_z, in_ch.origin_y, in_ch.origin_x};
            lraw <= {in_ch.left_z, in_ch.left_y, in_ch.left_x};
            rad_bot <= in_ch.bottom_radius;
            rad_top <= in_ch.top_radius;
            len <= in_ch.branch_length;
            nreq.neg <= {in_ch.heading_z[15], in_ch.heading_y[15], in_ch.heading_x[15]};
            nreq.mag[0] <= MAG_W'({(in_ch.heading_x[15] ? 16'(-in_ch.heading_x)
                                    : in_ch.heading_x), UNIT_SH'(0)});
            nreq.mag[1] <= MAG_W'({(in_ch.heading_y[15] ? 16'(-in_ch.heading_y)
                                    : in_ch.heading_y), UNIT_SH'(0)});
            nreq.mag[2] <= MAG_W'({(in_ch.heading_z[15] ? 16'(-in_ch.heading_z)
                                    : in_ch.heading_z), UNIT_SH'(0)});
            nstart <= 1'b1;
            state <= F_HEAD;
          end
        end
        F_HEAD: begin
          if (nstat.done) begin
            head <= nstat.res;
            nreq <= lreq;
            nstart <= 1'b1;
            state <= F_LEFT;
          end
        end
        F_LEFT: begin
          if (nstat.done) begin
            left <= nstat.res;
            cc <= '0;
            state <= F_CROSS;
          end
        end
        F_CROSS: begin
          cr[cc] <= cr_n[COORD_W-1:0];
          cc <= cc + 2'd1;
          if (cc == 2'd2) state <= F_UPGO;
        end
        F_UPGO: begin
          nreq <= ureq;
          nstart <= 1'b1;
          state <= F_UP;
        end
        F_UP: begin
          if (nstat.done) begin
            up <= nstat.res;
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (state == F_IDLE);
  assign q_push = (state == F_PUSH) && !q_full;

  always_comb begin
    q_din.org = org;
    q_din.head = head;
    q_din.left = left;
    q_din.up = up;
    q_din.rad_bot = rad_bot;
    q_din.rad_top = rad_top;
    q_din.len = len;
  end

endmodule

@@ src/ftr_queue.sv @@
// ----------------------------------------------------------------------------
// ftr_queue
// small register queue of prepared branches between front and back
// ----------------------------------------------------------------------------
module ftr_queue
  import ftr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  branch_t din,
  output logic    full,
  input  logic    pop,
  output branch_t dout,
  output logic    empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  branch_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [PTR_W:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) begin
        mem[wp] <= din;
        wp <= (wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) rp <= (rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign dout  = mem[rp];
  assign full  = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);

endmodule

@@ src/ftr_back.sv @@
// ----------------------------------------------------------------------------
// ftr_back
// walks both rings of a prepared branch, one vertex at a time
// ----------------------------------------------------------------------------
module ftr_back
  import ftr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  detail,
  input  logic        q_empty,
  input  branch_t     q_dout,
  output logic        q_pop,
  ftr_out_if.source   out_ch
);

  typedef enum logic [8:0] {
    B_IDLE = 9'b000000001,
    B_ANG  = 9'b000000010,
    B_DIR  = 9'b000000100,
    B_MUL  = 9'b000001000,
    B_RND  = 9'b000010000,
    B_SUM  = 9'b000100000,
    B_NGO  = 9'b001000000,
    B_NWT  = 9'b010000000,
    B_OUT  = 9'b100000000
  } bstate_t;

  bstate_t state;
  branch_t br;
  logic ring;
  logic [4:0] k;
  logic [1:0] comp;
  logic signed [DIR_W-1:0] sv, cv;
  logic signed [30:0] dir;
  logic signed [62:0] pr;
  logic signed [47:0] pu;
  logic signed [33:0] tr;
  logic signed [32:0] tu;
  logic [2:0][COORD_W-1:0] pos;

  norm_req_t nreq;
  norm_stat_t nstat;

  logic [2:0] sh;
  logic [4:0] m;
  logic [5:0] vcnt;
  logic [4:0] klast;
  logic is_last, out_free;
  logic [62:0] apr, ar;
  logic [47:0] apu, au;
  logic signed [35:0] psum;
  logic [COORD_W-1:0] psat;

  ftr_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (state == B_NGO),
    .req   (nreq),
    .stat  (nstat)
  );

  always_comb begin
    sh = 3'(MAX_DETAIL) - detail;
    m = 5'(k << sh);
    vcnt = 6'(6'd4 << (detail - 3'd1));
    klast = 5'(vcnt - 6'd1);
    is_last = ring && (k == klast);
    out_free = !out_ch.valid || out_ch.ready;

    // round half away from zero
    apr = pr[62] ? 63'(-pr) : 63'(pr);
    ar = (apr + (63'(1) << 27)) >> 28;
    apu = pu[47] ? 48'(-pu) : 48'(pu);
    au = (apu + (48'(1) << 13)) >> 14;

    psum = 36'($signed(br.org[comp])) + 36'(tr) + (ring ? 36'(tu) : 36'sd0);
    if (psum > 36'sh07FFFFFFF) psat = 32'h7FFFFFFF;
    else if (psum < -36'sh080000000) psat = 32'h80000000;
    else psat = psum[COORD_W-1:0];

    for (int i = 0; i < 3; i++) begin
      nreq.neg[i] = pos[i][COORD_W-1];
      nreq.mag[i] = pos[i][COORD_W-1] ? MAG_W'(-$signed(pos[i])) : pos[i];
    end
  end

  assign q_pop = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.ready && (state != B_OUT)) out_ch.valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            br <= q_dout;
            ring <= 1'b0;
            k <= '0;
            state <= B_ANG;
          end
        end
        B_ANG: begin
          sv <= sine_at(m);
          cv <= sine_at(m + 5'd8);
          comp <= '0;
          state <= B_DIR;
        end
        B_DIR: begin
          dir <= 31'($signed(br.head[comp]) * cv) + 31'($signed(br.left[comp]) * sv);
          state <= B_MUL;
        end
        B_MUL: begin
          pr <= 63'($signed({1'b0, (ring ? br.rad_top : br.rad_bot)}) * dir);
          pu <= 48'($signed({1'b0, br.len}) * $signed(br.up[comp]));
          state <= B_RND;
        end
        B_RND: begin
          tr <= pr[62] ? -$signed(34'(ar)) : $signed(34'(ar));
          tu <= pu[47] ? -$signed(33'(au)) : $signed(33'(au));
          state <= B_SUM;
        end
        B_SUM: begin
          pos[comp] <= psat;
          comp <= comp + 2'd1;
          state <= (comp == 2'd2) ? B_NGO : B_DIR;
        end
        B_NGO: state <= B_NWT;
        B_NWT: begin
          if (nstat.done) state <= B_OUT;
        end
        B_OUT: begin
          // output register is either free here or held with ready low
          if (out_free) begin
            out_ch.valid <= 1'b1;
            out_ch.vertex_index <= ring ? (vcnt + 6'(k)) : 6'(k);
            out_ch.pos_x <= pos[0];
            out_ch.pos_y <= pos[1];
            out_ch.pos_z <= pos[2];
            out_ch.norm_x <= nstat.res[0];
            out_ch.norm_y <= nstat.res[1];
            out_ch.norm_z <= nstat.res[2];
            out_ch.tex_u <= k;
            out_ch.tex_v <= ring ? TEX_V_TOP : 3'd0;
            out_ch.last <= is_last;
            if (is_last) begin
              state <= B_IDLE;
            end else begin
              if (k == klast) begin
                k <= '0;
                ring <= 1'b1;
              end else begin
                k <= k + 5'd1;
              end
              state <= B_ANG;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
